FILE: design/bdeq_pkg.sv
// Shared constants, types and helpers for the bounded double-ended queue.
package bdeq_pkg;

    localparam int DEPTH         = 16;
    localparam int PTR_W         = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W         = $clog2(DEPTH + 1);
    localparam int OP_W          = 3;
    localparam int VAL_W         = 32;
    localparam int STATUS_W      = 2;
    localparam int ENTRY_COUNT_W = 5;

    localparam logic [OP_W-1:0] OP_PUSH_FRONT = OP_W'(0);
    localparam logic [OP_W-1:0] OP_PUSH_BACK  = OP_W'(1);
    localparam logic [OP_W-1:0] OP_POP_FRONT  = OP_W'(2);
    localparam logic [OP_W-1:0] OP_POP_BACK   = OP_W'(3);
    localparam logic [OP_W-1:0] OP_DUMP       = OP_W'(4);

    localparam logic [STATUS_W-1:0] STATUS_OK    = STATUS_W'(0);
    localparam logic [STATUS_W-1:0] STATUS_FULL  = STATUS_W'(1);
    localparam logic [STATUS_W-1:0] STATUS_EMPTY = STATUS_W'(2);

    // Commands from the controller to the datapath.
    typedef struct packed {
        logic take;       // latch the request on a transfer
        logic exec;       // apply push or pop to the ring
        logic rd_en;      // issue a ring read
        logic rd_back;    // read address is the back entry
        logic rd_dump;    // read address is front plus walk index
        logic fix;        // refresh the front or back shadow from read data
        logic load_out;   // load the output register
        logic dump_item;  // output carries a dumped element; advance the walk
        logic idx_clr;    // restart the walk index
    } t_cmd;

    // Status from the datapath to the controller.
    typedef struct packed {
        logic [OP_W-1:0] opcode;
        logic            empty;
        logic            out_free;
        logic            last_idx;
    } t_sts;

    // Ring position a + b, for a below DEPTH and b at most DEPTH.
    function automatic logic [PTR_W-1:0] wrap_add(input logic [PTR_W-1:0] a,
                                                  input logic [CNT_W-1:0] b);
        logic [CNT_W:0] s;
        s = (CNT_W + 1)'(a) + (CNT_W + 1)'(b);
        if (s >= (CNT_W + 1)'(DEPTH)) begin
            s = s - (CNT_W + 1)'(DEPTH);
        end
        return s[PTR_W-1:0];
    endfunction

endpackage

FILE: design/bdeq_ifs.sv
// Request and response channel interfaces of the deque.
interface bdeq_req_if;
    logic                           valid;
    logic                           ready;
    logic [bdeq_pkg::OP_W-1:0]      opcode;
    logic signed [bdeq_pkg::VAL_W-1:0] value;

    modport source (output valid, output opcode, output value, input ready);
    modport sink   (input valid, input opcode, input value, output ready);
endinterface

interface bdeq_rsp_if;
    logic                                  valid;
    logic                                  ready;
    logic [bdeq_pkg::STATUS_W-1:0]         status;
    logic signed [bdeq_pkg::VAL_W-1:0]     item_value;
    logic signed [bdeq_pkg::VAL_W-1:0]     front_value;
    logic signed [bdeq_pkg::VAL_W-1:0]     back_value;
    logic [bdeq_pkg::ENTRY_COUNT_W-1:0]    entry_count;
    logic                                  is_empty;
    logic                                  last;

    modport source (output valid, output status, output item_value, output front_value,
                    output back_value, output entry_count, output is_empty,
                    output last, input ready);
    modport sink   (input valid, input status, input item_value, input front_value,
                    input back_value, input entry_count, input is_empty,
                    input last, output ready);
endinterface

FILE: design/bdeq_ctrl.sv
// Sequencer for the deque: one request at a time, dump walks one entry per pass.
module bdeq_ctrl (
    input  logic             i_clk,
    input  logic             i_rst_n,
    input  logic             i_in_valid,
    output logic             o_in_ready,
    input  bdeq_pkg::t_sts   i_sts,
    output bdeq_pkg::t_cmd   o_cmd
);

    localparam logic [2:0] S_IDLE = 3'd0;
    localparam logic [2:0] S_EXEC = 3'd1;
    localparam logic [2:0] S_RD   = 3'd2;
    localparam logic [2:0] S_FIX  = 3'd3;
    localparam logic [2:0] S_EMIT = 3'd4;
    localparam logic [2:0] S_DRD  = 3'd5;
    localparam logic [2:0] S_DLD  = 3'd6;

    logic [2:0] r_state;
    logic [2:0] n_state;

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    always_comb begin
        n_state    = r_state;
        o_cmd      = '0;
        o_in_ready = 1'b0;
        unique case (r_state)
            S_IDLE: begin
                o_in_ready = 1'b1;
                if (i_in_valid) begin
                    o_cmd.take = 1'b1;
                    n_state    = S_EXEC;
                end
            end
            S_EXEC: begin
                o_cmd.exec = 1'b1;
                unique case (i_sts.opcode) inside
                    bdeq_pkg::OP_POP_FRONT, bdeq_pkg::OP_POP_BACK: begin
                        n_state = i_sts.empty ? S_EMIT : S_RD;
                    end
                    bdeq_pkg::OP_DUMP: begin
                        o_cmd.idx_clr = 1'b1;
                        n_state       = i_sts.empty ? S_EMIT : S_DRD;
                    end
                    default: begin
                        n_state = S_EMIT;
                    end
                endcase
            end
            S_RD: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_back = (i_sts.opcode == bdeq_pkg::OP_POP_BACK);
                n_state       = S_FIX;
            end
            S_FIX: begin
                o_cmd.fix = 1'b1;
                n_state   = S_EMIT;
            end
            S_EMIT: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out = 1'b1;
                    n_state        = S_IDLE;
                end
            end
            S_DRD: begin
                o_cmd.rd_en   = 1'b1;
                o_cmd.rd_dump = 1'b1;
                n_state       = S_DLD;
            end
            S_DLD: begin
                if (i_sts.out_free) begin
                    o_cmd.load_out  = 1'b1;
                    o_cmd.dump_item = 1'b1;
                    n_state         = i_sts.last_idx ? S_IDLE : S_DRD;
                end
            end
            default: begin
                n_state = S_IDLE;
            end
        endcase
    end

endmodule

FILE: design/bdeq_dp.sv
// Ring memory, pointers, shadow end values and output register of the deque.
module bdeq_dp (
    input  logic                                  i_clk,
    input  logic                                  i_rst_n,
    input  bdeq_pkg::t_cmd                        i_cmd,
    output bdeq_pkg::t_sts                        o_sts,
    input  logic [bdeq_pkg::OP_W-1:0]             i_opcode,
    input  logic signed [bdeq_pkg::VAL_W-1:0]     i_value,
    input  logic                                  i_out_ready,
    output logic                                  o_out_valid,
    output logic [bdeq_pkg::STATUS_W-1:0]         o_status,
    output logic signed [bdeq_pkg::VAL_W-1:0]     o_item_value,
    output logic signed [bdeq_pkg::VAL_W-1:0]     o_front_value,
    output logic signed [bdeq_pkg::VAL_W-1:0]     o_back_value,
    output logic [bdeq_pkg::ENTRY_COUNT_W-1:0]    o_entry_count,
    output logic                                  o_is_empty,
    output logic                                  o_last
);

    logic [bdeq_pkg::VAL_W-1:0]    r_mem [bdeq_pkg::DEPTH];
    logic [bdeq_pkg::VAL_W-1:0]    r_rd_data;

    logic [bdeq_pkg::OP_W-1:0]     r_opcode;
    logic [bdeq_pkg::VAL_W-1:0]    r_value;
    logic [bdeq_pkg::PTR_W-1:0]    r_front, n_front;
    logic [bdeq_pkg::CNT_W-1:0]    r_count, n_count;
    logic [bdeq_pkg::VAL_W-1:0]    r_front_val, n_front_val;
    logic [bdeq_pkg::VAL_W-1:0]    r_back_val, n_back_val;
    logic [bdeq_pkg::STATUS_W-1:0] r_status, n_status;
    logic [bdeq_pkg::PTR_W-1:0]    r_idx;

    logic                          r_out_valid;
    logic [bdeq_pkg::STATUS_W-1:0] r_out_status;
    logic [bdeq_pkg::VAL_W-1:0]    r_out_item;
    logic [bdeq_pkg::VAL_W-1:0]    r_out_front;
    logic [bdeq_pkg::VAL_W-1:0]    r_out_back;
    logic [bdeq_pkg::CNT_W-1:0]    r_out_count;
    logic                          r_out_last;

    logic                          mem_we;
    logic [bdeq_pkg::PTR_W-1:0]    mem_waddr;
    logic [bdeq_pkg::PTR_W-1:0]    mem_raddr;
    logic                          empty;
    logic                          full;
    logic                          last_idx;

    assign empty    = (r_count == '0);
    assign full     = (r_count >= bdeq_pkg::CNT_W'(bdeq_pkg::DEPTH));
    assign last_idx = ((bdeq_pkg::CNT_W'(r_idx) + bdeq_pkg::CNT_W'(1)) == r_count);

    assign o_sts.opcode   = r_opcode;
    assign o_sts.empty    = empty;
    assign o_sts.out_free = !r_out_valid || i_out_ready;
    assign o_sts.last_idx = last_idx;

    // Apply a push or pop, or refresh an end shadow from read data; full and empty cases leave the ring untouched.
    always_comb begin
        n_front     = r_front;
        n_count     = r_count;
        n_front_val = r_front_val;
        n_back_val  = r_back_val;
        n_status    = r_status;
        mem_we      = 1'b0;
        mem_waddr   = r_front;
        if (i_cmd.exec) begin
            n_status = bdeq_pkg::STATUS_OK;
            case (r_opcode)
                bdeq_pkg::OP_PUSH_FRONT: begin
                    if (full) begin
                        n_status = bdeq_pkg::STATUS_FULL;
                    end else begin
                        mem_we      = 1'b1;
                        mem_waddr   = bdeq_pkg::wrap_add(r_front,
                                          bdeq_pkg::CNT_W'(bdeq_pkg::DEPTH - 1));
                        n_front     = mem_waddr;
                        n_count     = r_count + bdeq_pkg::CNT_W'(1);
                        n_front_val = r_value;
                        if (empty) begin
                            n_back_val = r_value;
                        end
                    end
                end
                bdeq_pkg::OP_PUSH_BACK: begin
                    if (full) begin
                        n_status = bdeq_pkg::STATUS_FULL;
                    end else begin
                        mem_we     = 1'b1;
                        mem_waddr  = bdeq_pkg::wrap_add(r_front, r_count);
                        n_count    = r_count + bdeq_pkg::CNT_W'(1);
                        n_back_val = r_value;
                        if (empty) begin
                            n_front_val = r_value;
                        end
                    end
                end
                bdeq_pkg::OP_POP_FRONT: begin
                    if (empty) begin
                        n_status = bdeq_pkg::STATUS_EMPTY;
                    end else begin
                        n_front = bdeq_pkg::wrap_add(r_front, bdeq_pkg::CNT_W'(1));
                        n_count = r_count - bdeq_pkg::CNT_W'(1);
                    end
                end
                bdeq_pkg::OP_POP_BACK: begin
                    if (empty) begin
                        n_status = bdeq_pkg::STATUS_EMPTY;
                    end else begin
                        n_count = r_count - bdeq_pkg::CNT_W'(1);
                    end
                end
                default: begin
                    n_status = bdeq_pkg::STATUS_OK;
                end
            endcase
        end
        if (i_cmd.fix) begin
            if (r_opcode == bdeq_pkg::OP_POP_FRONT) begin
                n_front_val = r_rd_data;
            end else begin
                n_back_val = r_rd_data;
            end
        end
    end

    always_comb begin
        if (i_cmd.rd_dump) begin
            mem_raddr = bdeq_pkg::wrap_add(r_front, bdeq_pkg::CNT_W'(r_idx));
        end else if (i_cmd.rd_back) begin
            mem_raddr = bdeq_pkg::wrap_add(r_front, r_count - bdeq_pkg::CNT_W'(1));
        end else begin
            mem_raddr = r_front;
        end
    end

    always_ff @(posedge i_clk) begin
        if (mem_we) begin
            r_mem[mem_waddr] <= r_value;
        end
        if (i_cmd.rd_en) begin
            r_rd_data <= r_mem[mem_raddr];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_front     <= '0;
            r_count     <= '0;
            r_idx       <= '0;
            r_out_valid <= 1'b0;
        end else begin
            r_front <= n_front;
            r_count <= n_count;
            if (i_cmd.idx_clr) begin
                r_idx <= '0;
            end else if (i_cmd.dump_item) begin
                r_idx <= r_idx + bdeq_pkg::PTR_W'(1);
            end
            if (i_cmd.load_out) begin
                r_out_valid <= 1'b1;
            end else if (i_out_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_cmd.take) begin
            r_opcode <= i_opcode;
            r_value  <= i_value;
        end
        r_front_val <= n_front_val;
        r_back_val  <= n_back_val;
        r_status    <= n_status;
        if (i_cmd.load_out) begin
            r_out_status <= i_cmd.dump_item ? bdeq_pkg::STATUS_OK : r_status;
            r_out_item   <= i_cmd.dump_item ? r_rd_data : '0;
            r_out_front  <= empty ? '0 : r_front_val;
            r_out_back   <= empty ? '0 : r_back_val;
            r_out_count  <= r_count;
            r_out_last   <= i_cmd.dump_item ? last_idx : 1'b1;
        end
    end

    assign o_out_valid   = r_out_valid;
    assign o_status      = r_out_status;
    assign o_item_value  = r_out_item;
    assign o_front_value = r_out_front;
    assign o_back_value  = r_out_back;
    assign o_entry_count = bdeq_pkg::ENTRY_COUNT_W'(r_out_count);
    assign o_is_empty    = (r_out_count == '0);
    assign o_last        = r_out_last;

`ifndef NO_ASSERTIONS
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= bdeq_pkg::CNT_W'(bdeq_pkg::DEPTH))
        else $error("entry count above depth");

    a_count_step: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        !$past(i_cmd.exec) |-> $stable(r_count))
        else $error("entry count moved outside a push or pop");

    a_load_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_cmd.load_out |-> (!r_out_valid || i_out_ready))
        else $error("output register overwritten before transfer");

    a_full_no_write: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (i_cmd.exec && full) |-> !mem_we)
        else $error("ring written while full");
`endif

endmodule

FILE: design/bounded_double_ended_queue.sv
// Sequence: a push, an unused opcode, an empty dump and a pop of an empty deque go from
// the transfer in through the execute state to the result load; any other pop first reads
// the ring and refreshes the end shadow; a dump reads and loads one stored entry per pass.
// One request at a time: the next request is taken once the previous
// result has been loaded into the output register.
// Reset (synchronous, active low) empties the deque and drops any pending result.
module bounded_double_ended_queue (
    input  logic        i_clk,
    input  logic        i_rst_n,
    bdeq_req_if.sink    i_req,
    bdeq_rsp_if.source  o_rsp
);

    bdeq_pkg::t_cmd cmd;
    bdeq_pkg::t_sts sts;

    // Controller: accepts a request, sequences the ring accesses and result loads.
    bdeq_ctrl u_ctrl (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_in_valid (i_req.valid),
        .o_in_ready (i_req.ready),
        .i_sts      (sts),
        .o_cmd      (cmd)
    );

    // Datapath: ring memory, front position, count, end shadows and result register.
    // Ring contents are not cleared at reset, since values from unwritten entries never reach the outputs.
    bdeq_dp u_dp (
        .i_clk         (i_clk),
        .i_rst_n       (i_rst_n),
        .i_cmd         (cmd),
        .o_sts         (sts),
        .i_opcode      (i_req.opcode),
        .i_value       (i_req.value),
        .i_out_ready   (o_rsp.ready),
        .o_out_valid   (o_rsp.valid),
        .o_status      (o_rsp.status),
        .o_item_value  (o_rsp.item_value),
        .o_front_value (o_rsp.front_value),
        .o_back_value  (o_rsp.back_value),
        .o_entry_count (o_rsp.entry_count),
        .o_is_empty    (o_rsp.is_empty),
        .o_last        (o_rsp.last)
    );

endmodule

FILE: verif/bdeq_scoreboard_pkg.sv
// Shadow deque and expected-result checker for the bounded double-ended queue testbench.
package bdeq_scoreboard_pkg;
    import bdeq_pkg::*;

    typedef struct packed {
        logic [STATUS_W-1:0]      status;
        logic signed [VAL_W-1:0]  item_value;
        logic signed [VAL_W-1:0]  front_value;
        logic signed [VAL_W-1:0]  back_value;
        logic [ENTRY_COUNT_W-1:0] entry_count;
        logic                     is_empty;
        logic                     last;
    } deque_result_t;

    class deque_mirror;
        logic signed [VAL_W-1:0] ring_copy [DEPTH];
        int unsigned             head_slot;
        int unsigned             fill_level;
        deque_result_t           pending_results [$];
        int unsigned             failures;

        function new();
            head_slot  = 0;
            fill_level = 0;
            failures   = 0;
        endfunction

        function int unsigned outstanding();
            return pending_results.size();
        endfunction

        // Append one expected result at the tail of the queue.
        function void append_expected(deque_result_t r);
            pending_results.insert(pending_results.size(), r);
        endfunction

        // Build one result from the shadow state as it stands now.
        function deque_result_t snapshot(logic [STATUS_W-1:0] status,
                                         logic signed [VAL_W-1:0] item,
                                         logic last);
            deque_result_t r;
            r.status      = status;
            r.item_value  = item;
            r.front_value = '0;
            r.back_value  = '0;
            if (fill_level != 0) begin
                r.front_value = ring_copy[head_slot];
                r.back_value  = ring_copy[(head_slot + fill_level - 1) % DEPTH];
            end
            r.entry_count = ENTRY_COUNT_W'(fill_level);
            r.is_empty    = (fill_level == 0);
            r.last        = last;
            return r;
        endfunction

        // Apply one accepted request and queue the results it causes.
        function void note_request(logic [OP_W-1:0] op, logic signed [VAL_W-1:0] val);
            logic [STATUS_W-1:0] status;
            status = STATUS_OK;
            case (op)
                OP_PUSH_FRONT: begin
                    if (fill_level >= DEPTH) begin
                        status = STATUS_FULL;
                    end else begin
                        head_slot = (head_slot + DEPTH - 1) % DEPTH;
                        ring_copy[head_slot] = val;
                        fill_level++;
                    end
                end
                OP_PUSH_BACK: begin
                    if (fill_level >= DEPTH) begin
                        status = STATUS_FULL;
                    end else begin
                        ring_copy[(head_slot + fill_level) % DEPTH] = val;
                        fill_level++;
                    end
                end
                OP_POP_FRONT: begin
                    if (fill_level == 0) begin
                        status = STATUS_EMPTY;
                    end else begin
                        head_slot = (head_slot + 1) % DEPTH;
                        fill_level--;
                    end
                end
                OP_POP_BACK: begin
                    if (fill_level == 0) begin
                        status = STATUS_EMPTY;
                    end else begin
                        fill_level--;
                    end
                end
                OP_DUMP: begin
                    if (fill_level != 0) begin
                        for (int unsigned i = 0; i < fill_level; i++) begin
                            append_expected(snapshot(STATUS_OK,
                                ring_copy[(head_slot + i) % DEPTH], i + 1 == fill_level));
                        end
                        return;
                    end
                end
                default: begin
                end
            endcase
            append_expected(snapshot(status, '0, 1'b1));
        endfunction

        function void compare_field(string field, longint want, longint seen);
            if (want != seen) begin
                $display("%0t: %s mismatch, expected %0d, actual %0d", $time, field, want, seen);
                failures++;
            end
        endfunction

        function void check_result(deque_result_t got);
            deque_result_t want;
            if (pending_results.size() == 0) begin
                $display("%0t: result with nothing expected, status %0d item %0d count %0d",
                         $time, got.status, got.item_value, got.entry_count);
                failures++;
                return;
            end
            want = pending_results[0];
            pending_results.delete(0);
            compare_field("status", want.status, got.status);
            compare_field("item_value", want.item_value, got.item_value);
            compare_field("front_value", want.front_value, got.front_value);
            compare_field("back_value", want.back_value, got.back_value);
            compare_field("entry_count", want.entry_count, got.entry_count);
            compare_field("is_empty", want.is_empty, got.is_empty);
            compare_field("last", want.last, got.last);
        endfunction
    endclass

endpackage

FILE: verif/bounded_double_ended_queue_tb.sv
// Randomized handshake testbench for the bounded double-ended queue.
module bounded_double_ended_queue_tb;
    timeunit 1ns;
    timeprecision 1ps;

    import bdeq_pkg::*;
    import bdeq_scoreboard_pkg::*;

    // Opcodes past dump are ignored by the block but still answered.
    localparam logic [OP_W-1:0] OP_UNUSED_LO = OP_DUMP + 1'b1;
    localparam logic [OP_W-1:0] OP_UNUSED_HI = '1;
    localparam int RANDOM_ITEMS = 180;
    localparam int HOLD_OFF_CYCLES = 80;
    localparam int SETTLE_CYCLES = 20;

    localparam logic signed [VAL_W-1:0] VAL_MIN = {1'b1, {(VAL_W-1){1'b0}}};
    localparam logic signed [VAL_W-1:0] VAL_MAX = {1'b0, {(VAL_W-1){1'b1}}};

    // Run shapes for the random part.
    typedef enum int {RUN_FILL, RUN_DRAIN, RUN_MIXED} run_kind_e;

    logic i_clk;
    logic i_rst_n;

    bdeq_req_if req_bus ();
    bdeq_rsp_if rsp_bus ();

    bounded_double_ended_queue i_dut (
        .i_clk  (i_clk),
        .i_rst_n(i_rst_n),
        .i_req  (req_bus),
        .o_rsp  (rsp_bus)
    );

    deque_mirror mirror = new();

    // Idle controls: each side draws a random wait per item while its switch is on.
    bit send_idle_on = 1'b1;
    bit recv_idle_on = 1'b1;
    int unsigned next_gap = 0;
    int unsigned hold_cycles = 0;
    int unsigned random_count = 0;

    initial begin
        i_clk = 1'b0;
        forever #5 i_clk = ~i_clk;
    end

    // Give up well past the slowest legal run.
    initial begin
        #3_000_000;
        $display("bounded_double_ended_queue_tb failed");
        $finish;
    end

    // Response side: stall at random, honor a requested long hold-off, check every transfer.
    initial begin : response_sink
        int unsigned stall;
        deque_result_t got;
        rsp_bus.ready <= 1'b0;
        @(posedge i_clk);
        forever begin
            if (hold_cycles > 0) begin
                stall = hold_cycles;
                hold_cycles = 0;
            end else begin
                stall = recv_idle_on ? $urandom_range(0, 8) : 0;
            end
            // Lower ready only when a stall is drawn, so ready never toggles within one step.
            if (stall > 0) begin
                rsp_bus.ready <= 1'b0;
                repeat (stall) @(posedge i_clk);
            end
            rsp_bus.ready <= 1'b1;
            do @(posedge i_clk); while (!rsp_bus.valid);
            got.status      = rsp_bus.status;
            got.item_value  = rsp_bus.item_value;
            got.front_value = rsp_bus.front_value;
            got.back_value  = rsp_bus.back_value;
            got.entry_count = rsp_bus.entry_count;
            got.is_empty    = rsp_bus.is_empty;
            got.last        = rsp_bus.last;
            mirror.check_result(got);
        end
    end

    // Offer one request, wait for its transfer, and record it in the shadow deque.
    // The gap before the following request is drawn here, so valid drops right away
    // when a gap follows and stays high for a back-to-back request.
    task automatic offer_request(input logic [OP_W-1:0] op,
                                 input logic signed [VAL_W-1:0] val);
        if (next_gap > 0) begin
            repeat (next_gap) @(posedge i_clk);
        end
        req_bus.valid  <= 1'b1;
        req_bus.opcode <= op;
        req_bus.value  <= val;
        do @(posedge i_clk); while (!req_bus.ready);
        mirror.note_request(op, val);
        next_gap = send_idle_on ? $urandom_range(0, 8) : 0;
        if (next_gap > 0) begin
            req_bus.valid <= 1'b0;
        end
    endtask

    // Drop valid (if still held for a back-to-back request) and wait out all results.
    task automatic pause_until_drained();
        if (next_gap == 0) begin
            req_bus.valid <= 1'b0;
        end
        while (mirror.outstanding() != 0) @(posedge i_clk);
    endtask

    // Favor boundary values; otherwise spread over all 32 bits.
    function automatic logic signed [VAL_W-1:0] pick_value();
        case ($urandom_range(0, 9))
            0: return VAL_MIN;
            1: return VAL_MAX;
            2: return '1;
            3: return '0;
            4: return VAL_W'($urandom_range(0, 15));
            default: return $urandom();
        endcase
    endfunction

    function automatic logic [OP_W-1:0] pick_push();
        return $urandom_range(0, 1) ? OP_PUSH_BACK : OP_PUSH_FRONT;
    endfunction

    function automatic logic [OP_W-1:0] pick_pop();
        return $urandom_range(0, 1) ? OP_POP_BACK : OP_POP_FRONT;
    endfunction

    // One random request shaped by the current run; ignored opcodes are not counted.
    task automatic issue_random(input run_kind_e kind);
        int unsigned roll;
        logic [OP_W-1:0] op;
        roll = $urandom_range(0, 99);
        if (roll < 3) begin
            offer_request(OP_W'($urandom_range(OP_UNUSED_LO, OP_UNUSED_HI)), pick_value());
        end else begin
            case (kind)
                RUN_FILL:  op = (roll < 83) ? pick_push() : (roll < 93) ? pick_pop() : OP_DUMP;
                RUN_DRAIN: op = (roll < 80) ? pick_pop() : (roll < 90) ? pick_push() : OP_DUMP;
                default:   op = OP_W'($urandom_range(OP_PUSH_FRONT, OP_DUMP));
            endcase
            offer_request(op, pick_value());
            random_count++;
        end
    endtask

    initial begin : stimulus
        run_kind_e kind;
        int unsigned run_len;

        req_bus.valid  <= 1'b0;
        req_bus.opcode <= OP_PUSH_FRONT;
        req_bus.value  <= '0;
        i_rst_n        <= 1'b0;
        repeat (10) @(posedge i_clk);
        i_rst_n <= 1'b1;

        // Directed: empty-deque errors, ignored opcodes, extremes, single-element pops.
        offer_request(OP_POP_FRONT, '0);
        offer_request(OP_POP_BACK, '1);
        offer_request(OP_DUMP, '0);
        offer_request(OP_UNUSED_LO, VAL_MAX);
        offer_request(OP_UNUSED_HI, VAL_MIN);
        offer_request(OP_PUSH_BACK, VAL_MAX);
        offer_request(OP_PUSH_FRONT, VAL_MIN);
        offer_request(OP_PUSH_BACK, '1);
        offer_request(OP_PUSH_FRONT, '0);
        offer_request(OP_PUSH_BACK, 32'sd1);
        offer_request(OP_DUMP, '0);
        offer_request(OP_POP_FRONT, '0);
        offer_request(OP_POP_BACK, '0);
        offer_request(OP_POP_FRONT, '0);
        offer_request(OP_POP_BACK, '0);
        // Pop the only element from the back, then from the front.
        offer_request(OP_POP_BACK, '0);
        offer_request(OP_PUSH_FRONT, 32'sh5555_5555);
        offer_request(OP_POP_FRONT, '0);
        offer_request(OP_PUSH_BACK, 32'shAAAA_AAAA);
        offer_request(OP_DUMP, '0);
        offer_request(OP_POP_FRONT, '0);
        offer_request(OP_UNUSED_LO + 1'b1, '0);

        // Sender pause: hold off until every result has come back.
        pause_until_drained();

        // Back-pressure: the receiver holds off for a long stretch while the sender
        // keeps offering pushes back to back, so results back up and the block stalls its input.
        hold_cycles  = HOLD_OFF_CYCLES;
        send_idle_on = 1'b0;
        repeat (10) offer_request(pick_push(), pick_value());
        send_idle_on = 1'b1;
        pause_until_drained();

        // Fill to the brim from both ends, push into a full deque, dump it, then drain.
        while (mirror.fill_level < DEPTH) begin
            offer_request(pick_push(), pick_value());
            random_count++;
        end
        offer_request(OP_PUSH_FRONT, pick_value());
        offer_request(OP_PUSH_BACK, pick_value());
        offer_request(OP_DUMP, '0);
        random_count += 3;
        while (mirror.fill_level > 0) begin
            offer_request(pick_pop(), pick_value());
            random_count++;
        end

        // Random runs: push-heavy, pop-heavy or uniform, with idling switched per run.
        while (random_count < RANDOM_ITEMS) begin
            kind         = run_kind_e'($urandom_range(RUN_FILL, RUN_MIXED));
            run_len      = $urandom_range(8, 24);
            send_idle_on = ($urandom_range(0, 9) < 7);
            recv_idle_on = ($urandom_range(0, 9) < 7);
            repeat (run_len) issue_random(kind);
        end

        // Drain, then let the block settle so any stray result shows up.
        send_idle_on = 1'b1;
        recv_idle_on = 1'b1;
        pause_until_drained();
        repeat (SETTLE_CYCLES) @(posedge i_clk);

        if (mirror.failures == 0 && mirror.outstanding() == 0) begin
            $display("bounded_double_ended_queue_tb passed");
        end else begin
            $display("bounded_double_ended_queue_tb failed");
        end
        $finish;
    end

endmodule
